@@ design/vpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared types and constants for the velocity packet parser.
// ----------------------------------------------------------------------------
package vpp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hFF;
  localparam logic [7:0] MOTION_CODE  = 8'h02;
  localparam logic [7:0] MIN_LENGTH   = 8'd4;
  localparam int         PAYLOAD_DEPTH = 6;
  localparam int         IDX_W        = $clog2(PAYLOAD_DEPTH + 1);
  localparam int         VEL_W        = 16;
  localparam int         CFG_DATA_W   = 16;

  localparam logic [7:0]  RESET_DEVICE_ID = 8'd1;
  localparam logic [15:0] RESET_TIMEOUT   = 16'd100;

  // Input item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic CFG_OWN_ID  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_ID    = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_FUNC  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } phase_t;

  // Per-byte outcome from the parser
  typedef struct packed {
    logic                    accepted;
    logic                    cks_err;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } parse_result_t;

endpackage : vpp_pkg
`default_nettype wire

@@ design/vpp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpp_in_if / vpp_out_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface vpp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface : vpp_in_if

interface vpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_x_milli;
  logic signed [15:0] linear_y_milli;
  logic signed [15:0] angular_z_milli;
  logic               packet_accepted;
  logic               checksum_error;
  logic               command_live;

  modport source (output valid, output linear_x_milli, output linear_y_milli,
                  output angular_z_milli, output packet_accepted,
                  output checksum_error, output command_live, input ready);
  modport sink   (input valid, input linear_x_milli, input linear_y_milli,
                  input angular_z_milli, input packet_accepted,
                  input checksum_error, input command_live, output ready);
endinterface : vpp_out_if
`default_nettype wire

@@ design/vpp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpp_parser
// Byte-wise packet parser: header hunt, id/length/function check, payload
// capture and 8-bit sum checksum. Reports the outcome of each byte.
// ----------------------------------------------------------------------------
module vpp_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            own_id,
  output vpp_pkg::parse_result_t     result
);
  import vpp_pkg::*;

  phase_t            phase, phase_next;
  logic [7:0]        pkt_len, pkt_len_next;
  logic [7:0]        pkt_func, pkt_func_next;
  logic [7:0]        remaining, remaining_next;
  logic [IDX_W-1:0]  data_idx, data_idx_next;
  logic [7:0]        run_sum, run_sum_next;
  logic [7:0]        payload [PAYLOAD_DEPTH];
  logic              payload_we;
  logic [7:0]        rem_dec;
  logic              accepted, cks_err;

  // Phase and field decode for the current byte
  always_comb begin
    phase_next     = phase;
    pkt_len_next   = pkt_len;
    pkt_func_next  = pkt_func;
    remaining_next = remaining;
    data_idx_next  = data_idx;
    run_sum_next   = run_sum;
    payload_we     = 1'b0;
    accepted       = 1'b0;
    cks_err        = 1'b0;
    rem_dec        = (remaining != 8'd0) ? remaining - 8'd1 : remaining;
    if (byte_valid) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == HEADER_BYTE) begin
            run_sum_next = rx_byte;
            phase_next   = PH_ID;
          end
        end
        PH_ID: begin
          if (rx_byte == own_id) begin
            run_sum_next = run_sum + rx_byte;
            phase_next   = PH_LEN;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_LEN: begin
          pkt_len_next = rx_byte;
          run_sum_next = run_sum + rx_byte;
          phase_next   = (rx_byte <= MIN_LENGTH) ? PH_HUNT : PH_FUNC;
        end
        PH_FUNC: begin
          pkt_func_next  = rx_byte;
          run_sum_next   = run_sum + rx_byte;
          remaining_next = pkt_len - MIN_LENGTH;
          data_idx_next  = '0;
          phase_next     = PH_DATA;
        end
        PH_DATA: begin
          // store the first bytes, count the rest only toward the sum
          payload_we = (data_idx < IDX_W'(PAYLOAD_DEPTH));
          if (data_idx < IDX_W'(PAYLOAD_DEPTH)) begin
            data_idx_next = data_idx + 1'b1;
          end
          run_sum_next   = run_sum + rx_byte;
          remaining_next = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (run_sum == rx_byte) begin
            accepted = (pkt_func == MOTION_CODE) && (data_idx == IDX_W'(PAYLOAD_DEPTH));
          end else begin
            cks_err = 1'b1;
          end
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      pkt_len   <= '0;
      pkt_func  <= '0;
      remaining <= '0;
      data_idx  <= '0;
      run_sum   <= '0;
    end else begin
      phase     <= phase_next;
      pkt_len   <= pkt_len_next;
      pkt_func  <= pkt_func_next;
      remaining <= remaining_next;
      data_idx  <= data_idx_next;
      run_sum   <= run_sum_next;
    end
  end

  // Capture payload bytes
  always_ff @(posedge clk) begin
    if (payload_we) begin
      payload[data_idx[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Little-endian velocity words from the stored payload
  always_comb begin
    result.accepted = accepted;
    result.cks_err  = cks_err;
    result.vel_x    = {payload[1], payload[0]};
    result.vel_y    = {payload[3], payload[2]};
    result.vel_z    = {payload[5], payload[4]};
  end

endmodule : vpp_parser
`default_nettype wire

@@ design/velocity_packet_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_packet_parser
// Serial motion-packet parser with a millisecond command watchdog.
//
//   channel   dir  payload                                  transfer when
//   in_ch     in   cmd, rx_byte                             valid && ready
//   out_ch    out  three velocities, accepted, cks error,   valid && ready
//                  command live
//   cfg       in   cfg_we, cfg_index, cfg_data              cfg_we
//
// One item per cycle unless stalled; each accepted item's result is in the
// output register in the next cycle. The input is ready whenever the
// output register is empty or being drained in the same cycle, so a
// stalled output stops intake after one item. Synchronous reset returns
// to header hunt with zero velocities, id 1 and a timeout of 100 ticks.
// ----------------------------------------------------------------------------
module velocity_packet_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  vpp_in_if.sink                            in_ch,
  vpp_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [vpp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vpp_pkg::*;

  logic [7:0]              own_id;
  logic [15:0]             timeout;
  logic [15:0]             ticks, ticks_next;
  logic signed [VEL_W-1:0] vel [3];
  logic signed [VEL_W-1:0] vel_next [3];
  logic                    take;
  logic                    is_tick;
  logic                    live_next;
  parse_result_t           pres;

  assign take          = in_ch.valid && in_ch.ready;
  assign is_tick       = (in_ch.cmd == CMD_TICK);
  assign in_ch.ready   = !out_ch.valid || out_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id  <= RESET_DEVICE_ID;
      timeout <= RESET_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:  own_id  <= cfg_data[7:0];
        CFG_TIMEOUT: timeout <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  vpp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (take && !is_tick),
    .rx_byte    (in_ch.rx_byte),
    .own_id     (own_id),
    .result     (pres)
  );

  // Watchdog count and velocity update
  always_comb begin
    ticks_next = ticks;
    vel_next   = vel;
    if (take && is_tick) begin
      if (ticks != 16'hFFFF) begin
        ticks_next = ticks + 16'd1;
      end
    end else if (pres.accepted) begin
      ticks_next  = '0;
      vel_next[0] = pres.vel_x;
      vel_next[1] = pres.vel_y;
      vel_next[2] = pres.vel_z;
    end
    live_next = (ticks_next <= timeout);
    if (!live_next) begin
      vel_next[0] = '0;
      vel_next[1] = '0;
      vel_next[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= '0;
      vel   <= '{default: '0};
    end else if (take) begin
      ticks <= ticks_next;
      vel   <= vel_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (take) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.linear_x_milli  <= vel_next[0];
      out_ch.linear_y_milli  <= vel_next[1];
      out_ch.angular_z_milli <= vel_next[2];
      out_ch.packet_accepted <= pres.accepted;
      out_ch.checksum_error  <= pres.cks_err;
      out_ch.command_live    <= live_next;
    end
  end

  // A byte never both completes a packet and fails its checksum
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.packet_accepted && out_ch.checksum_error))
    else $error("accepted and checksum error both set");

  // Tick items raise no packet flags
  a_tick_no_flags: assert property (@(posedge clk) disable iff (rst)
    (take && is_tick) |=> (!out_ch.packet_accepted && !out_ch.checksum_error))
    else $error("flag raised on tick item");

  // An expired command reports zero velocities
  a_expired_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.command_live) |->
      (out_ch.linear_x_milli == '0 && out_ch.linear_y_milli == '0 &&
       out_ch.angular_z_milli == '0))
    else $error("velocity nonzero after timeout");

  // An accepted packet restarts the watchdog
  a_accept_live: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.packet_accepted) |-> (ticks == 16'd0))
    else $error("watchdog not restarted");

endmodule : velocity_packet_parser
`default_nettype wire
